// ===== rtl/tpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types, codes and channel arithmetic for the texture pixel combiner
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int CH_W    = 8;
    localparam int OP_W    = 3;
    localparam int SCALE_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD          = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_NORMALS  = 3'd1;
    localparam logic [OP_W-1:0] OP_SCALE        = 3'd2;
    localparam logic [OP_W-1:0] OP_INVERT_ALPHA = 3'd3;
    localparam logic [OP_W-1:0] OP_INVERT_COLOR = 3'd4;
    localparam logic [OP_W-1:0] OP_INTENSITY    = 3'd5;
    localparam logic [OP_W-1:0] OP_MAKE_ALPHA   = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_ALPHA = 3'd3;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'h0100;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pixel_t;

    // (a + b) / 2, round half to even
    function automatic logic [CH_W-1:0] avg_rne(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        logic [CH_W:0] s;
        logic [CH_W:0] q;
        s = {1'b0, a} + {1'b0, b};
        q = {1'b0, s[CH_W:1]} + {{CH_W{1'b0}}, s[0] & s[1]};
        return q[CH_W-1:0];
    endfunction

    // p * f / 256, round half to even, saturate at 255
    function automatic logic [CH_W-1:0] scale_rne(input logic [CH_W-1:0] p,
                                                  input logic [SCALE_W-1:0] f);
        logic [CH_W+SCALE_W-1:0] prod;
        logic [SCALE_W:0]        q;
        logic                    inc;
        prod = {{SCALE_W{1'b0}}, p} * {{CH_W{1'b0}}, f};
        inc  = (prod[7:0] > 8'd128) || ((prod[7:0] == 8'd128) && prod[8]);
        q    = {1'b0, prod[CH_W+SCALE_W-1:8]} + {{SCALE_W{1'b0}}, inc};
        return (q > {{(SCALE_W+1-CH_W){1'b0}}, CH_MAX}) ? CH_MAX : q[CH_W-1:0];
    endfunction

    // floor(x / 3) for x up to 765, reciprocal 683 / 2048
    function automatic logic [CH_W-1:0] div3(input logic [9:0] x);
        logic [19:0] m;
        m = {10'd0, x} * 20'd683;
        return m[18:11];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/texture_pixel_combiner_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// texture_pixel_combiner_core
// rgba8 pixel combiner: average, normal average, scale, inversions, make alpha, intensity
// ----------------------------------------------------------------------------
// One pixel per clock, sustained while out_ready is high. A transfer on the
// input lands in an input register; from there the whole operation is worked
// out in one pass and written to the result register once it is free. The
// longest path is the 8x16 scale multiply with its rounding and saturation.
// The two registers form a short pipeline: the input register still takes a
// pixel while a finished result waits, and in_ready drops only once both
// registers are full and out_ready is low. Scale registers reset to 1.0
// (0x0100) and are to be written by the user through cfg_write /
// cfg_index / cfg_data only while the block is idle; it does not enforce this.
module texture_pixel_combiner_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpc_pkg::SCALE_W-1:0]     cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tpc_pkg::OP_W-1:0]        opcode,
    input  logic [tpc_pkg::CH_W-1:0]        first_red,
    input  logic [tpc_pkg::CH_W-1:0]        first_green,
    input  logic [tpc_pkg::CH_W-1:0]        first_blue,
    input  logic [tpc_pkg::CH_W-1:0]        first_alpha,
    input  logic [tpc_pkg::CH_W-1:0]        second_red,
    input  logic [tpc_pkg::CH_W-1:0]        second_green,
    input  logic [tpc_pkg::CH_W-1:0]        second_blue,
    input  logic [tpc_pkg::CH_W-1:0]        second_alpha,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tpc_pkg::CH_W-1:0]        out_red,
    output logic [tpc_pkg::CH_W-1:0]        out_green,
    output logic [tpc_pkg::CH_W-1:0]        out_blue,
    output logic [tpc_pkg::CH_W-1:0]        out_alpha
);
    import tpc_pkg::*;

    logic [SCALE_W-1:0] scale_red_reg;
    logic [SCALE_W-1:0] scale_green_reg;
    logic [SCALE_W-1:0] scale_blue_reg;
    logic [SCALE_W-1:0] scale_alpha_reg;

    logic               in_valid_reg;
    logic [OP_W-1:0]    op_reg;
    pixel_t             pix_a_reg;
    pixel_t             pix_b_reg;

    logic               out_valid_reg;
    pixel_t             res_reg;
    pixel_t             res_next;

    logic               out_free;
    logic               advance;
    logic               in_take;
    logic [9:0]         rgb_sum;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_red_reg   <= SCALE_ONE;
            scale_green_reg <= SCALE_ONE;
            scale_blue_reg  <= SCALE_ONE;
            scale_alpha_reg <= SCALE_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCALE_RED:   scale_red_reg   <= cfg_data;
                REG_SCALE_GREEN: scale_green_reg <= cfg_data;
                REG_SCALE_BLUE:  scale_blue_reg  <= cfg_data;
                REG_SCALE_ALPHA: scale_alpha_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= opcode;
            pix_a_reg <= '{red: first_red, green: first_green,
                           blue: first_blue, alpha: first_alpha};
            pix_b_reg <= '{red: second_red, green: second_green,
                           blue: second_blue, alpha: second_alpha};
        end
    end

    // ---------------- single-pass datapath ----------------
    assign rgb_sum = {2'b00, pix_a_reg.red} + {2'b00, pix_a_reg.green}
                   + {2'b00, pix_a_reg.blue};

    always_comb
    begin
        res_next = pix_a_reg;
        case (op_reg)
            OP_ADD:
            begin
                res_next.red   = avg_rne(pix_a_reg.red,   pix_b_reg.red);
                res_next.green = avg_rne(pix_a_reg.green, pix_b_reg.green);
                res_next.blue  = avg_rne(pix_a_reg.blue,  pix_b_reg.blue);
                res_next.alpha = avg_rne(pix_a_reg.alpha, pix_b_reg.alpha);
            end
            OP_ADD_NORMALS:
            begin
                res_next.red   = avg_rne(pix_a_reg.red,   pix_b_reg.red);
                res_next.green = avg_rne(pix_a_reg.green, pix_b_reg.green);
                res_next.blue  = avg_rne(pix_a_reg.blue,  pix_b_reg.blue);
                res_next.alpha = CH_MAX;
            end
            OP_SCALE:
            begin
                res_next.red   = scale_rne(pix_a_reg.red,   scale_red_reg);
                res_next.green = scale_rne(pix_a_reg.green, scale_green_reg);
                res_next.blue  = scale_rne(pix_a_reg.blue,  scale_blue_reg);
                res_next.alpha = scale_rne(pix_a_reg.alpha, scale_alpha_reg);
            end
            OP_INVERT_ALPHA:
            begin
                res_next.alpha = CH_MAX - pix_a_reg.alpha;
            end
            OP_INVERT_COLOR:
            begin
                res_next.red   = CH_MAX - pix_a_reg.red;
                res_next.green = CH_MAX - pix_a_reg.green;
                res_next.blue  = CH_MAX - pix_a_reg.blue;
            end
            OP_INTENSITY:
            begin
                res_next.green = pix_a_reg.red;
                res_next.blue  = pix_a_reg.red;
                res_next.alpha = pix_a_reg.red;
            end
            OP_MAKE_ALPHA:
            begin
                res_next.red   = CH_MAX;
                res_next.green = CH_MAX;
                res_next.blue  = CH_MAX;
                res_next.alpha = div3(rgb_sum);
            end
            default:
            begin
                // unused opcode passes the first pixel through
                res_next = pix_a_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = res_reg.red;
    assign out_green = res_reg.green;
    assign out_blue  = res_reg.blue;
    assign out_alpha = res_reg.alpha;

endmodule
`default_nettype wire

// ===== rtl/tpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_checker
// port-level checks of the pixel combiner pipeline, bound to the top level
// ----------------------------------------------------------------------------
module tpc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_red,
    input  logic [7:0] out_green,
    input  logic [7:0] out_blue,
    input  logic [7:0] out_alpha
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled result keeps its pixel
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
                                    && $stable(out_blue) && $stable(out_alpha))
        else $error("result pixel changed while stalled");

    // with the result register empty the input never blocks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    // a draining output always frees the input side
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output drains");

    // an input transfer followed by a drain cycle yields a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("result missing two cycles after transfer");

endmodule

bind texture_pixel_combiner_core tpc_checker u_tpc_checker (.*);
`default_nettype wire

// ===== test/tpc_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pixel_checker
// watches the pixel channels and the register port of the texture pixel
// combiner, works out each result pixel and compares it with the block
// ----------------------------------------------------------------------------
module tpc_pixel_checker
    import tpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SCALE_W-1:0]   cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [OP_W-1:0]      opcode,
    input  logic [CH_W-1:0]      first_red,
    input  logic [CH_W-1:0]      first_green,
    input  logic [CH_W-1:0]      first_blue,
    input  logic [CH_W-1:0]      first_alpha,
    input  logic [CH_W-1:0]      second_red,
    input  logic [CH_W-1:0]      second_green,
    input  logic [CH_W-1:0]      second_blue,
    input  logic [CH_W-1:0]      second_alpha,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [CH_W-1:0]      out_red,
    input  logic [CH_W-1:0]      out_green,
    input  logic [CH_W-1:0]      out_blue,
    input  logic [CH_W-1:0]      out_alpha,
    output int unsigned          pending,
    output int unsigned          results_seen,
    output int unsigned          mismatches
);

    logic [SCALE_W-1:0] factor_red;
    logic [SCALE_W-1:0] factor_green;
    logic [SCALE_W-1:0] factor_blue;
    logic [SCALE_W-1:0] factor_alpha;
    pixel_t             expected_pixels [$];

    // midpoint of two channels, exact halves go to the even neighbor
    function automatic logic [CH_W-1:0] mean_even(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        int unsigned sum;
        int unsigned half;
        sum  = a + b;
        half = sum / 2;
        if ((sum % 2 == 1) && (half % 2 == 1))
            half = half + 1;
        return CH_W'(half);
    endfunction

    // channel times an 8.8 factor, nearest with ties to even, clipped at full
    function automatic logic [CH_W-1:0] scaled(input logic [CH_W-1:0]    p,
                                               input logic [SCALE_W-1:0] f);
        int unsigned prod;
        int unsigned whole;
        int unsigned frac;
        prod  = p * f;
        whole = prod / 256;
        frac  = prod % 256;
        if (frac > 128 || (frac == 128 && whole % 2 == 1))
            whole = whole + 1;
        return (whole > CH_MAX) ? CH_MAX : CH_W'(whole);
    endfunction

    function automatic pixel_t blend_pixel(input logic [OP_W-1:0] op,
                                           input pixel_t a,
                                           input pixel_t b);
        pixel_t      res;
        int unsigned total;
        res = a;
        case (op)
            OP_ADD, OP_ADD_NORMALS:
            begin
                res.red   = mean_even(a.red, b.red);
                res.green = mean_even(a.green, b.green);
                res.blue  = mean_even(a.blue, b.blue);
                res.alpha = (op == OP_ADD) ? mean_even(a.alpha, b.alpha) : CH_MAX;
            end
            OP_SCALE:
            begin
                res.red   = scaled(a.red, factor_red);
                res.green = scaled(a.green, factor_green);
                res.blue  = scaled(a.blue, factor_blue);
                res.alpha = scaled(a.alpha, factor_alpha);
            end
            OP_INVERT_ALPHA:
                res.alpha = CH_MAX - a.alpha;
            OP_INVERT_COLOR:
            begin
                res.red   = CH_MAX - a.red;
                res.green = CH_MAX - a.green;
                res.blue  = CH_MAX - a.blue;
            end
            OP_INTENSITY:
                res = {4{a.red}};
            OP_MAKE_ALPHA:
            begin
                total = a.red + a.green + a.blue;
                res   = {CH_MAX, CH_MAX, CH_MAX, CH_W'(total / 3)};
            end
            default:
                ; // unused opcode leaves the first pixel as it is
        endcase
        return res;
    endfunction

    function automatic int unsigned channel_bad(input string           name,
                                                input logic [CH_W-1:0] want,
                                                input logic [CH_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t      want;
        pixel_t      got;
        int unsigned bad;
        if (!rst_n)
        begin
            factor_red   <= SCALE_ONE;
            factor_green <= SCALE_ONE;
            factor_blue  <= SCALE_ONE;
            factor_alpha <= SCALE_ONE;
            expected_pixels.delete();
            pending      <= 0;
            results_seen <= 0;
            mismatches   <= 0;
        end
        else
        begin
            bad = 0;
            // the output side first, so a result never meets its own transfer
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                got = {out_red, out_green, out_blue, out_alpha};
                if (expected_pixels.size() == 0)
                begin
                    $error("result pixel %h with no transfer waiting for it", got);
                    bad = 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    bad = channel_bad("out_red", want.red, got.red)
                        + channel_bad("out_green", want.green, got.green)
                        + channel_bad("out_blue", want.blue, got.blue)
                        + channel_bad("out_alpha", want.alpha, got.alpha);
                end
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(blend_pixel(opcode,
                    {first_red, first_green, first_blue, first_alpha},
                    {second_red, second_green, second_blue, second_alpha}));
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SCALE_RED:   factor_red   <= cfg_data;
                    REG_SCALE_GREEN: factor_green <= cfg_data;
                    REG_SCALE_BLUE:  factor_blue  <= cfg_data;
                    REG_SCALE_ALPHA: factor_alpha <= cfg_data;
                    default:         ; // no register there
                endcase
            end
            mismatches <= mismatches + bad;
            pending    <= expected_pixels.size();
        end
    end

endmodule

// ===== test/texture_pixel_combiner_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_pixel_combiner_core_tb
// directed and random pixel streams through every opcode and several scale
// settings, with random idling on both channels and two long output holds
// ----------------------------------------------------------------------------
module texture_pixel_combiner_core_tb;

    import tpc_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED       = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_STRAY_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRAY_LAST  = 3'd7;

    localparam int RESET_CYCLES   = 3;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 325;
    localparam int HOLD_COUNT     = 2;
    localparam int HOLD_START     = 500;
    localparam int HOLD_SPACING   = 650;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [OP_W-1:0]      opcode;
    logic [CH_W-1:0]      first_red;
    logic [CH_W-1:0]      first_green;
    logic [CH_W-1:0]      first_blue;
    logic [CH_W-1:0]      first_alpha;
    logic [CH_W-1:0]      second_red;
    logic [CH_W-1:0]      second_green;
    logic [CH_W-1:0]      second_blue;
    logic [CH_W-1:0]      second_alpha;
    logic                 out_valid;
    logic                 out_ready;
    logic [CH_W-1:0]      out_red;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_blue;
    logic [CH_W-1:0]      out_alpha;
    int unsigned          pending;
    int unsigned          results_seen;
    int unsigned          mismatches;
    int unsigned          quiet_cycles = 0;
    bit                   gaps_on = 1'b1;

    texture_pixel_combiner_core i_dut (.*);

    tpc_pixel_checker i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short idles, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [CH_W-1:0] pick_channel();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CH_MAX;
        if (r == 2)
            return CH_W'($urandom_range(126, 129));
        return CH_W'($urandom);
    endfunction

    function automatic pixel_t pick_pixel();
        return {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
    endfunction

    function automatic pixel_t px(input int unsigned r, input int unsigned g,
                                  input int unsigned b, input int unsigned a);
        return {CH_W'(r), CH_W'(g), CH_W'(b), CH_W'(a)};
    endfunction

    function automatic logic [SCALE_W-1:0] pick_factor();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_ONE;
            3:       return SCALE_W'($urandom_range(0, 511));
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    task automatic offer_pixel(input logic [OP_W-1:0] op, input pixel_t a,
                               input pixel_t b);
        int unsigned gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        first_red    <= a.red;
        first_green  <= a.green;
        first_blue   <= a.blue;
        first_alpha  <= a.alpha;
        second_red   <= b.red;
        second_green <= b.green;
        second_blue  <= b.blue;
        second_alpha <= b.alpha;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every result pixel has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_scales(input logic [SCALE_W-1:0] r,
                                  input logic [SCALE_W-1:0] g,
                                  input logic [SCALE_W-1:0] b,
                                  input logic [SCALE_W-1:0] a,
                                  input bit                 stray);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= REG_SCALE_RED;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= REG_SCALE_GREEN;
        cfg_data  <= g;
        @(posedge clk);
        cfg_index <= REG_SCALE_BLUE;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= REG_SCALE_ALPHA;
        cfg_data  <= a;
        @(posedge clk);
        // a write past the last register must leave the factors alone
        if (stray)
        begin
            cfg_index <= CFG_IDX_W'($urandom_range(REG_STRAY_FIRST, REG_STRAY_LAST));
            cfg_data  <= SCALE_W'($urandom);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // output side: random stalls, long stretches of no stall, and a couple of
    // long holds so the block fills up and pushes back on the input
    initial
    begin
        int unsigned holds_done;
        int unsigned run;
        int unsigned stall;
        holds_done = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_done < HOLD_COUNT
                    && results_seen >= HOLD_START + holds_done * HOLD_SPACING)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                run = ($urandom_range(99) < 6) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
                out_ready <= 1'b1;
                repeat (run) @(posedge clk);
                stall = idle_len();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        bit stray;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        opcode       = OP_ADD;
        first_red    = '0;
        first_green  = '0;
        first_blue   = '0;
        first_alpha  = '0;
        second_red   = '0;
        second_green = '0;
        second_blue  = '0;
        second_alpha = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rounding ties, extremes and each opcode at the reset factors
        offer_pixel(OP_ADD, px(0, 0, 0, 0), px(255, 255, 255, 255));
        offer_pixel(OP_ADD, px(255, 255, 255, 255), px(255, 255, 255, 255));
        offer_pixel(OP_ADD, px(1, 3, 0, 2), px(2, 0, 255, 255));
        offer_pixel(OP_ADD_NORMALS, px(0, 0, 0, 0), px(255, 255, 255, 0));
        offer_pixel(OP_ADD_NORMALS, px(10, 11, 12, 200), px(13, 12, 12, 7));
        offer_pixel(OP_SCALE, px(255, 0, 128, 1), pick_pixel());
        offer_pixel(OP_INVERT_ALPHA, px(1, 2, 3, 0), pick_pixel());
        offer_pixel(OP_INVERT_ALPHA, px(255, 255, 255, 255), pick_pixel());
        offer_pixel(OP_INVERT_COLOR, px(0, 255, 128, 77), pick_pixel());
        offer_pixel(OP_INTENSITY, px(0, 255, 255, 255), pick_pixel());
        offer_pixel(OP_INTENSITY, px(170, 1, 2, 3), pick_pixel());
        offer_pixel(OP_MAKE_ALPHA, px(255, 255, 255, 0), pick_pixel());
        offer_pixel(OP_MAKE_ALPHA, px(0, 0, 0, 255), pick_pixel());
        offer_pixel(OP_MAKE_ALPHA, px(2, 2, 1, 9), pick_pixel());
        offer_pixel(OP_MAKE_ALPHA, px(254, 255, 255, 40), pick_pixel());
        offer_pixel(OP_UNUSED, px(12, 34, 56, 78), pick_pixel());

        // zero factor, full factor, one half (ties) and one and a half
        program_scales(16'h0000, 16'hFFFF, 16'h0080, 16'h0180, 1'b1);
        offer_pixel(OP_SCALE, px(255, 255, 255, 255), pick_pixel());
        offer_pixel(OP_SCALE, px(1, 1, 1, 1), pick_pixel());
        offer_pixel(OP_SCALE, px(3, 0, 3, 0), pick_pixel());
        offer_pixel(OP_SCALE, px(0, 1, 5, 170), pick_pixel());

        for (int ph = 0; ph < PHASES; ph++)
        begin
            stray = 1'($urandom_range(1));
            case (ph)
                0:       program_scales('1, '1, '1, '1, stray);
                1:       program_scales('0, '0, '0, '0, stray);
                default: program_scales(pick_factor(), pick_factor(), pick_factor(),
                                        pick_factor(), stray);
            endcase
            // one phase streams back to back from the sender
            gaps_on = (ph != 2);
            repeat (PHASE_ITEMS)
                offer_pixel(OP_W'($urandom_range(OP_ADD, OP_UNUSED)), pick_pixel(),
                            pick_pixel());
        end

        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
